@@ hdl/gmm_pkg.sv @@
package gmm_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [15:0] Q15_ONE        = 16'h8000;
   localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;
   localparam logic [29:0] RAD_TO_BAM_Q32 = 30'd683565276;
   localparam logic [15:0] QUARTER_TURN   = 16'h4000;
   localparam logic [15:0] HALF_TURN      = 16'h8000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FIELD_X,
      CSR_FIELD_Y,
      CSR_ALPHA,
      CSR_GAIN,
      CSR_MEAN_SPEED,
      CSR_INIT_HEADING,
      CSR_PERIOD,
      CSR_EDGE_MODE
   } csr_index_type;

   typedef enum logic [1:0] {
      EDGE_WRAP,
      EDGE_RECENTRE,
      EDGE_CLAMP,
      EDGE_REFLECT
   } edge_mode_type;

   typedef enum logic {
      OP_ADVANCE,
      OP_PLACE
   } opcode_type;

   typedef enum logic [3:0] {
      STEP_NONE,
      STEP_PLACE,
      STEP_AV,
      STEP_AM,
      STEP_GV,
      STEP_AD,
      STEP_GH,
      STEP_GHK,
      STEP_HEAD,
      STEP_SINRD,
      STEP_SC,
      STEP_SCT,
      STEP_SS,
      STEP_SST,
      STEP_EY,
      STEP_EX
   } step_type;

   typedef struct packed {
      step_type step;
      logic     load;
      logic     publish;
   } cmd_type;

   // Q1.15 sine of a Q30 angle in [0, pi/2], Taylor series to x^15
   function automatic logic [15:0] sine_entry(input logic [63:0] x);
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic signed [63:0] v;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      term = ((term * x2) >> 30) / 6;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 20;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 42;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 72;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 110;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 156;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 210;
      sum  = sum - $signed(term);
      v = (sum + 64'sd16384) >>> 15;
      if (v < 0) begin
         v = '0;
      end
      if (v > 64'sd32768) begin
         v = 64'sd32768;
      end
      return v[15:0];
   endfunction

endpackage

@@ hdl/gmm_req_if.sv @@
interface gmm_req_if;
   logic               valid;
   logic               ready;
   logic               opcode;
   logic signed [31:0] place_x;
   logic signed [31:0] place_y;
   logic signed [15:0] speed_sample;
   logic signed [15:0] heading_sample;

   modport source (output valid, opcode, place_x, place_y, speed_sample, heading_sample,
                   input ready);
   modport sink (input valid, opcode, place_x, place_y, speed_sample, heading_sample,
                 output ready);
endinterface

@@ hdl/gmm_rsp_if.sv @@
interface gmm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] cur_speed;
   logic [15:0]        cur_heading;

   modport source (output valid, pos_x, pos_y, cur_speed, cur_heading, input ready);
   modport sink (input valid, pos_x, pos_y, cur_speed, cur_heading, output ready);
endinterface

@@ hdl/gmm_sine_rom.sv @@
module gmm_sine_rom #(
   parameter int SINE_TABLE_ENTRIES = 1024
) (
   input  logic                                         clock,
   input  logic [$clog2(SINE_TABLE_ENTRIES + 1)-1:0]    addr,
   output logic [15:0]                                  data
);
   import gmm_pkg::*;

   typedef logic [15:0] tab_type [SINE_TABLE_ENTRIES + 1];

   function automatic tab_type build_table();
      tab_type     t;
      logic [63:0] x;
      for (int i = 0; i <= SINE_TABLE_ENTRIES; i++) begin
         x    = HALF_PI_Q30 * 64'(i) / SINE_TABLE_ENTRIES;
         t[i] = sine_entry(x);
      end
      return t;
   endfunction

   localparam tab_type SINE_TAB = build_table();

   logic [15:0] data_ff;

   always_ff @(posedge clock) begin
      data_ff <= SINE_TAB[addr];
   end

   assign data = data_ff;
endmodule

@@ hdl/gmm_datapath.sv @@
module gmm_datapath #(
   parameter int SINE_TABLE_ENTRIES = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [gmm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [gmm_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  gmm_pkg::cmd_type                    cmd,
   input  logic signed [31:0]                  in_place_x,
   input  logic signed [31:0]                  in_place_y,
   input  logic signed [15:0]                  in_speed_sample,
   input  logic signed [15:0]                  in_heading_sample,
   output logic signed [31:0]                  pos_x,
   output logic signed [31:0]                  pos_y,
   output logic signed [31:0]                  cur_speed,
   output logic [15:0]                         cur_heading
);
   import gmm_pkg::*;

   localparam int IDX_W = $clog2(SINE_TABLE_ENTRIES + 1);
   localparam int QN_W  = 15 + IDX_W;
   localparam int WW    = 52;
   localparam logic signed [WW-1:0] SAT_MAX = WW'(64'sd2147483647);
   localparam logic signed [WW-1:0] SAT_MIN = WW'(-64'sd2147483648);

   function automatic logic signed [31:0] sat32(input logic signed [WW-1:0] v);
      if (v > SAT_MAX) begin
         return 32'sh7FFF_FFFF;
      end
      if (v < SAT_MIN) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   // configuration
   logic [30:0]        fwx_ff, fwy_ff, period_ff;
   logic [15:0]        alpha_ff, gain_ff, init_head_ff;
   logic signed [31:0] mean_speed_ff;
   edge_mode_type      edge_ff;

   // node state
   logic signed [31:0] node_x_ff, node_y_ff, node_speed_ff;
   logic [15:0]        node_head_ff, head_mean_ff;

   // captured item and work registers
   logic signed [31:0] px_ff, py_ff;
   logic signed [15:0] vs_ff, hs_ff;
   logic signed [67:0] prod_ff;
   logic signed [47:0] acc_ff;
   logic signed [63:0] hacc_ff;
   logic [15:0]        new_head_ff;
   logic signed [16:0] cos_ff, sin_ff;
   logic               quad_neg_ff;
   logic signed [48:0] dx_ff;
   logic signed [WW-1:0] nx_ff, ny_ff, ox_ff, oy_ff;

   // result register
   logic signed [31:0] pos_x_ff, pos_y_ff, speed_out_ff;
   logic [15:0]        head_out_ff;

   logic [15:0]        alpha_c, gain_c;
   logic [16:0]        one_minus_a;
   logic signed [15:0] head_diff;
   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] mul_p;
   logic signed [67:0] p_r15, p_r16;
   logic signed [WW-1:0] spd_r;
   logic signed [63:0] hsum, hround;
   logic [15:0]        head_calc;
   logic [15:0]        look_ang;
   logic [14:0]        look_q;
   logic [QN_W-1:0]    look_qn;
   logic [IDX_W-1:0]   rom_addr;
   logic [15:0]        rom_q;
   logic signed [16:0] rom_signed;

   logic signed [WW-1:0] wx, wy, ox0, oy0, nx0, ny0;
   logic signed [WW-1:0] ey_nx, ey_ny, ey_oy;
   logic [15:0]          ey_h;
   logic signed [WW-1:0] ex_nx, ex_ny, ex_ox;
   logic [15:0]          ex_h;

   assign alpha_c     = (alpha_ff > Q15_ONE) ? Q15_ONE : alpha_ff;
   assign gain_c      = (gain_ff > Q15_ONE) ? Q15_ONE : gain_ff;
   assign one_minus_a = {1'b0, Q15_ONE} - {1'b0, alpha_c};
   assign head_diff   = $signed(node_head_ff - head_mean_ff);

   assign p_r15  = (prod_ff + 68'sd16384) >>> 15;
   assign p_r16  = (prod_ff + 68'sd32768) >>> 16;
   assign spd_r  = (WW'(acc_ff) + WW'(64'sd16384)) >>> 15;
   assign hsum   = hacc_ff + $signed(prod_ff[63:0]);
   assign hround = (hsum + 64'sd4398046511104) >>> 43;
   assign head_calc = head_mean_ff + hround[15:0];

   // shared multiplier, operands picked by step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.step)
         STEP_AV: begin
            mul_a = $signed({18'd0, alpha_c});
            mul_b = 34'(node_speed_ff);
         end
         STEP_AM: begin
            mul_a = $signed({17'd0, one_minus_a});
            mul_b = 34'(mean_speed_ff);
         end
         STEP_GV: begin
            mul_a = $signed({18'd0, gain_c});
            mul_b = 34'(vs_ff);
         end
         STEP_AD: begin
            mul_a = $signed({18'd0, alpha_c});
            mul_b = 34'(head_diff);
         end
         STEP_GH: begin
            mul_a = $signed({18'd0, gain_c});
            mul_b = 34'(hs_ff);
         end
         STEP_GHK: begin
            mul_a = $signed(prod_ff[33:0]);
            mul_b = $signed({4'd0, RAD_TO_BAM_Q32});
         end
         STEP_SC: begin
            mul_a = 34'(node_speed_ff);
            mul_b = 34'(cos_ff);
         end
         STEP_SS: begin
            mul_a = 34'(node_speed_ff);
            mul_b = 34'(sin_ff);
         end
         STEP_SCT, STEP_SST: begin
            mul_a = $signed(p_r15[33:0]);
            mul_b = $signed({3'd0, period_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // quarter-wave lookup; cosine is sine a quarter turn on
   assign look_ang = (cmd.step == STEP_HEAD) ? head_calc + QUARTER_TURN : new_head_ff;
   assign look_q   = look_ang[14] ? 15'd16384 - {1'b0, look_ang[13:0]}
                                  : {1'b0, look_ang[13:0]};
   assign look_qn  = QN_W'(look_q) * QN_W'(SINE_TABLE_ENTRIES);
   assign rom_addr = look_qn[14 +: IDX_W];
   assign rom_signed = quad_neg_ff ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});

   gmm_sine_rom #(
      .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
   ) u_rom (
      .clock(clock),
      .addr (rom_addr),
      .data (rom_q)
   );

   // edge handling, y first
   assign wx  = $signed({21'd0, fwx_ff});
   assign wy  = $signed({21'd0, fwy_ff});
   assign ox0 = WW'(node_x_ff);
   assign oy0 = WW'(node_y_ff);
   assign nx0 = ox0 + WW'(dx_ff);
   assign ny0 = oy0 + WW'($signed(p_r16[48:0]));

   always_comb begin
      ey_nx = nx0;
      ey_ny = ny0;
      ey_oy = oy0;
      ey_h  = new_head_ff;
      if (ny0 > wy || ny0 < 0) begin
         case (edge_ff)
            EDGE_WRAP: begin
               if (ny0 > 0) begin
                  ey_oy = oy0 - wy;
                  ey_ny = ny0 - wy;
               end else begin
                  ey_oy = oy0 + wy;
                  ey_ny = ny0 + wy;
               end
            end
            EDGE_RECENTRE: begin
               ey_nx = wx >>> 1;
               ey_ny = wy >>> 1;
            end
            EDGE_CLAMP: begin
               ey_ny = (ny0 < 0) ? '0 : wy;
            end
            default: begin
               if (ny0 > wy) begin
                  ey_ny = (wy <<< 1) - ny0;
                  ey_oy = (wy <<< 1) - oy0;
               end else begin
                  ey_ny = -ny0;
                  ey_oy = -oy0;
               end
               ey_h = 16'd0 - new_head_ff;
            end
         endcase
      end
   end

   always_comb begin
      ex_nx = nx_ff;
      ex_ny = ny_ff;
      ex_ox = ox_ff;
      ex_h  = new_head_ff;
      if (nx_ff > wx || nx_ff < 0) begin
         case (edge_ff)
            EDGE_WRAP: begin
               if (nx_ff > 0) begin
                  ex_ox = ox_ff - wx;
                  ex_nx = nx_ff - wx;
               end else begin
                  ex_ox = ox_ff + wx;
                  ex_nx = nx_ff + wx;
               end
            end
            EDGE_RECENTRE: begin
               ex_nx = wx >>> 1;
               ex_ny = wy >>> 1;
            end
            EDGE_CLAMP: begin
               ex_nx = (nx_ff < 0) ? '0 : wx;
            end
            default: begin
               if (nx_ff > wx) begin
                  ex_nx = (wx <<< 1) - nx_ff;
                  ex_ox = (wx <<< 1) - ox_ff;
               end else begin
                  ex_nx = -nx_ff;
                  ex_ox = -ox_ff;
               end
               if (ny_ff == oy_ff) begin
                  ex_h = (ex_nx > ex_ox) ? 16'd0 : HALF_TURN;
               end else begin
                  ex_h = HALF_TURN - new_head_ff;
               end
            end
         endcase
      end
   end

   // configuration and node state
   always_ff @(posedge clock) begin
      if (reset) begin
         fwx_ff        <= '0;
         fwy_ff        <= '0;
         alpha_ff      <= '0;
         gain_ff       <= Q15_ONE;
         mean_speed_ff <= '0;
         init_head_ff  <= '0;
         period_ff     <= 31'd65536;
         edge_ff       <= EDGE_REFLECT;
         node_x_ff     <= '0;
         node_y_ff     <= '0;
         node_speed_ff <= '0;
         node_head_ff  <= '0;
         head_mean_ff  <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_FIELD_X:      fwx_ff        <= csr_wdata[30:0];
               CSR_FIELD_Y:      fwy_ff        <= csr_wdata[30:0];
               CSR_ALPHA:        alpha_ff      <= csr_wdata[15:0];
               CSR_GAIN:         gain_ff       <= csr_wdata[15:0];
               CSR_MEAN_SPEED:   mean_speed_ff <= $signed(csr_wdata);
               CSR_INIT_HEADING: init_head_ff  <= csr_wdata[15:0];
               CSR_PERIOD:       period_ff     <= csr_wdata[30:0];
               CSR_EDGE_MODE:    edge_ff       <= edge_mode_type'(csr_wdata[1:0]);
               default:          fwx_ff        <= fwx_ff;
            endcase
         end
         if (cmd.step == STEP_PLACE) begin
            node_x_ff     <= px_ff;
            node_y_ff     <= py_ff;
            node_speed_ff <= mean_speed_ff;
            node_head_ff  <= init_head_ff;
            head_mean_ff  <= init_head_ff;
         end
         if (cmd.step == STEP_GH) begin
            node_speed_ff <= sat32(spd_r);
         end
         if (cmd.step == STEP_EX) begin
            node_x_ff    <= sat32(ex_nx);
            node_y_ff    <= sat32(ex_ny);
            node_head_ff <= ex_h;
            head_mean_ff <= ex_h;
         end
      end
   end

   // work and result registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_p;
      if (cmd.load) begin
         px_ff <= in_place_x;
         py_ff <= in_place_y;
         vs_ff <= in_speed_sample;
         hs_ff <= in_heading_sample;
      end
      unique case (cmd.step)
         STEP_AM: acc_ff  <= $signed(prod_ff[47:0]);
         STEP_GV: acc_ff  <= acc_ff + $signed(prod_ff[47:0]);
         STEP_AD: acc_ff  <= acc_ff + ($signed(prod_ff[47:0]) <<< 4);
         STEP_GH: hacc_ff <= $signed({prod_ff[35:0], 28'd0});
         STEP_HEAD: begin
            new_head_ff <= head_calc;
            quad_neg_ff <= look_ang[15];
         end
         STEP_SINRD: begin
            cos_ff      <= rom_signed;
            quad_neg_ff <= look_ang[15];
         end
         STEP_SC:  sin_ff <= rom_signed;
         STEP_SS:  dx_ff  <= $signed(p_r16[48:0]);
         STEP_EY: begin
            nx_ff       <= ey_nx;
            ny_ff       <= ey_ny;
            oy_ff       <= ey_oy;
            ox_ff       <= ox0;
            new_head_ff <= ey_h;
         end
         default: acc_ff <= acc_ff;
      endcase
      if (cmd.publish) begin
         pos_x_ff     <= node_x_ff;
         pos_y_ff     <= node_y_ff;
         speed_out_ff <= node_speed_ff;
         head_out_ff  <= node_head_ff;
      end
   end

   assign pos_x       = pos_x_ff;
   assign pos_y       = pos_y_ff;
   assign cur_speed   = speed_out_ff;
   assign cur_heading = head_out_ff;
endmodule

@@ hdl/gmm_control.sv @@
module gmm_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_opcode,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output gmm_pkg::cmd_type cmd
);
   import gmm_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_PLACE, S_AV, S_AM, S_GV, S_AD, S_GH, S_GHK, S_HEAD,
      S_SINRD, S_SC, S_SCT, S_SS, S_SST, S_EY, S_EX, S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      publish;

   assign publish = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      cmd.step = STEP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = (opcode_type'(req_opcode) == OP_PLACE) ? S_PLACE : S_AV;
            end
         end
         S_PLACE: begin cmd.step = STEP_PLACE; state_in = S_FINISH; end
         S_AV:    begin cmd.step = STEP_AV;    state_in = S_AM;     end
         S_AM:    begin cmd.step = STEP_AM;    state_in = S_GV;     end
         S_GV:    begin cmd.step = STEP_GV;    state_in = S_AD;     end
         S_AD:    begin cmd.step = STEP_AD;    state_in = S_GH;     end
         S_GH:    begin cmd.step = STEP_GH;    state_in = S_GHK;    end
         S_GHK:   begin cmd.step = STEP_GHK;   state_in = S_HEAD;   end
         S_HEAD:  begin cmd.step = STEP_HEAD;  state_in = S_SINRD;  end
         S_SINRD: begin cmd.step = STEP_SINRD; state_in = S_SC;     end
         S_SC:    begin cmd.step = STEP_SC;    state_in = S_SCT;    end
         S_SCT:   begin cmd.step = STEP_SCT;   state_in = S_SS;     end
         S_SS:    begin cmd.step = STEP_SS;    state_in = S_SST;    end
         S_SST:   begin cmd.step = STEP_SST;   state_in = S_EY;     end
         S_EY:    begin cmd.step = STEP_EY;    state_in = S_EX;     end
         S_EX:    begin cmd.step = STEP_EX;    state_in = S_FINISH; end
         S_FINISH: begin
            if (publish) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      cmd.load     = (state_ff == S_IDLE) && req_valid;
      cmd.publish  = publish;
      rsp_valid_in = publish ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
endmodule

@@ hdl/gauss_markov_mobility_step.sv @@
// Gauss-Markov mobility tick for one node. An advance beat (opcode 0)
// updates speed and heading by the AR(1) rule from the supplied Gaussian
// samples, moves the node by speed * cos/sin(heading) * period and applies
// the configured field-edge mode; a place beat (opcode 1) puts the node at
// the given point with mean speed and the initial heading. Each request
// beat gives exactly one response beat carrying the new state.
// An advance runs 14 datapath steps after acceptance, each a pass
// through the single shared 34x34 multiplier, a sine table read or
// edge handling, then a hand-off to the response register; a place
// runs one step and the hand-off. One item is in flight at a time; the
// next request is taken as soon as the previous result sits in the
// response register, even if that response has not been taken yet.
// CSRs must be written only while the block is idle; it does not check.
module gauss_markov_mobility_step #(
   parameter int SINE_TABLE_ENTRIES = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [gmm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [gmm_pkg::CSR_DATA_W-1:0]   csr_wdata,
   gmm_req_if.sink                          req_bus,
   gmm_rsp_if.source                        rsp_bus
);
   import gmm_pkg::*;

   cmd_type cmd;   // sequencer step plus load/publish strobes

   gmm_control u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_opcode(req_bus.opcode),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   // datapath: CSRs, node state, shared multiplier, sine table, edge logic
   gmm_datapath #(
      .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .in_place_x       (req_bus.place_x),
      .in_place_y       (req_bus.place_y),
      .in_speed_sample  (req_bus.speed_sample),
      .in_heading_sample(req_bus.heading_sample),
      .pos_x            (rsp_bus.pos_x),
      .pos_y            (rsp_bus.pos_y),
      .cur_speed        (rsp_bus.cur_speed),
      .cur_heading      (rsp_bus.cur_heading)
   );

   // a load strobe only on an accepted request beat
   a_load_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (req_bus.valid && req_bus.ready))
      else $error("load without request beat");

   // accepting a request makes the block busy next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("ready after accept");

   // publishing never overwrites a response that is still pending
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_bus.valid || rsp_bus.ready))
      else $error("response overwritten");

   a_publish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> rsp_bus.valid)
      else $error("publish without response");
endmodule
